// ----- design/lis_pkg.sv -----
// Package for the longest increasing subsequence unit.
// Holds the payload structs, the token and control structs and the mode codes.
// No dependencies; every other design file imports it.
package lis_pkg;

    localparam int C_MAX_LEN = 64;
    localparam int CHAR_W    = 8;
    localparam int LEN_W     = 7;

    localparam logic [1:0] MODE_INS  = 2'd0;
    localparam logic [1:0] MODE_MAX  = 2'd1;
    localparam logic [1:0] MODE_MARK = 2'd2;
    localparam logic [1:0] MODE_EMIT = 2'd3;

    typedef struct packed {
        logic [CHAR_W-1:0] in_char;
        logic              final_char;
    } t_in_item;

    typedef struct packed {
        logic [CHAR_W-1:0] out_char;
        logic [LEN_W-1:0]  seq_length;
        logic              overflow;
        logic              last_out;
    } t_out_item;

    // Token that travels from low to high cell index.
    typedef struct packed {
        logic              v;
        logic [CHAR_W-1:0] c;
        logic [LEN_W-1:0]  len;
        logic [LEN_W-1:0]  idx;
    } t_tok;

    // Token that travels from high to low cell index while marking the path.
    typedef struct packed {
        logic             v;
        logic [LEN_W-1:0] want;
    } t_btok;

    typedef struct packed {
        logic [1:0]       mode;
        logic [LEN_W-1:0] cnt;
        logic             hold;
        logic             flush;
    } t_cell_ctl;

    typedef struct packed {
        logic              req;
        logic [CHAR_W-1:0] ch;
    } t_emit;

endpackage

// ----- design/longest_increasing_subsequence_unit.sv -----
// Longest strictly increasing subsequence unit: top level with sequencer and output register.
// Depends on lis_pkg and lis_chain (which instantiates lis_cell).
//
// Usage: bytes of a string arrive on the input channel (i_in_valid / o_in_ready,
// payload i_in_data), one transfer per byte, final_char set on the last one.
// Bytes are compared as unsigned values. Up to MAX_LEN bytes are stored; more
// bytes are dropped and mark the result with the overflow flag.
// A non-final byte produces nothing. It runs as a token down a chain of
// MAX_LEN cells, one cell per cycle, until it lands in its own cell, and
// only then is the unit ready again. A dropped non-final byte leaves the
// unit idle. After the final byte three more sweeps run: one forward pass
// finds the earliest cell with the longest run, one backward pass marks its
// path, and a forward emit pass sends the marked bytes in order on the
// output channel (o_out_valid / i_out_ready, payload o_out_data), at most
// one transfer per cycle. o_in_ready is high only while no byte is in
// progress. The output register decouples the two sides: when the receiver
// stalls, the emit token waits on its cell and nothing is lost. Synchronous
// active-low reset empties the string, clears the overflow flag and the
// output valid flag; stored bytes and the output data keep no reset value.
module longest_increasing_subsequence_unit #(
    parameter int MAX_LEN = lis_pkg::C_MAX_LEN
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  lis_pkg::t_in_item i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output lis_pkg::t_out_item o_out_data
);
    import lis_pkg::*;

    localparam int               STEP_W    = $clog2(MAX_LEN);
    localparam logic [LEN_W-1:0] MAX_CNT   = LEN_W'(MAX_LEN);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(MAX_LEN - 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_INS  = 3'd1;
    localparam logic [2:0] S_MAXP = 3'd2;
    localparam logic [2:0] S_MARK = 3'd3;
    localparam logic [2:0] S_EMIT = 3'd4;

    logic [2:0]        r_state, n_state;
    logic [LEN_W-1:0]  r_cnt, n_cnt;
    logic              r_drop, n_drop;
    logic [CHAR_W-1:0] r_char, n_char;
    logic              r_fin, n_fin;
    logic              r_first, n_first;
    logic [STEP_W-1:0] r_step, n_step;
    logic [LEN_W-1:0]  r_len, n_len;
    logic [LEN_W-1:0]  r_end, n_end;
    logic [LEN_W-1:0]  r_emit, n_emit;
    t_out_item         r_out;
    logic              r_ovalid;

    t_cell_ctl w_ctl;
    t_tok      w_inj;
    t_btok     w_binj;
    t_tok      w_tok_end;
    t_emit     w_em;
    logic      w_in_acc;
    logic      w_hold;
    logic      w_load;
    logic      w_last;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_hold     = r_ovalid && !i_out_ready;
    assign w_load     = (r_state == S_EMIT) && w_em.req && !w_hold;
    assign w_last     = (r_emit + LEN_W'(1)) == r_len;

    // Broadcast control for the cells.
    always_comb begin
        case (r_state)
            S_MAXP:  w_ctl.mode = MODE_MAX;
            S_MARK:  w_ctl.mode = MODE_MARK;
            S_EMIT:  w_ctl.mode = MODE_EMIT;
            default: w_ctl.mode = MODE_INS;
        endcase
        w_ctl.cnt   = r_cnt;
        w_ctl.hold  = w_hold;
        w_ctl.flush = w_load && w_last;
    end

    // Tokens are injected in the first cycle of each pass.
    always_comb begin
        w_inj.v   = r_first && ((r_state == S_INS) || (r_state == S_MAXP) ||
                                (r_state == S_EMIT));
        w_inj.c   = r_char;
        w_inj.len = (r_state == S_INS) ? LEN_W'(1) : '0;
        w_inj.idx = '0;
        w_binj.v    = r_first && (r_state == S_MARK);
        w_binj.want = r_end;
    end

    lis_chain #(
        .MAX_LEN(MAX_LEN)
    ) u_chain (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctl  (w_ctl),
        .i_tok  (w_inj),
        .i_btok (w_binj),
        .o_tok  (w_tok_end),
        .o_emit (w_em)
    );

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_drop  = r_drop;
        n_char  = r_char;
        n_fin   = r_fin;
        n_first = 1'b0;
        n_step  = r_step;
        n_len   = r_len;
        n_end   = r_end;
        n_emit  = r_emit;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_char = i_in_data.in_char;
                    n_fin  = i_in_data.final_char;
                    if (r_cnt < MAX_CNT) begin
                        n_state = S_INS;
                        n_first = 1'b1;
                        n_step  = '0;
                    end else begin
                        // Store full: drop the byte, but a final mark still
                        // starts the output from what is stored.
                        n_drop = 1'b1;
                        if (i_in_data.final_char) begin
                            n_state = S_MAXP;
                            n_first = 1'b1;
                        end
                    end
                end
            end
            S_INS: begin
                n_step = r_step + STEP_W'(1);
                if (LEN_W'(r_step) == r_cnt) begin
                    n_cnt   = r_cnt + LEN_W'(1);
                    n_state = r_fin ? S_MAXP : S_IDLE;
                    n_first = r_fin;
                end
            end
            S_MAXP: begin
                if (w_tok_end.v) begin
                    n_len   = w_tok_end.len;
                    n_end   = w_tok_end.idx;
                    n_state = S_MARK;
                    n_first = 1'b1;
                    n_step  = '0;
                end
            end
            S_MARK: begin
                n_step = r_step + STEP_W'(1);
                if (r_step == LAST_STEP) begin
                    n_state = S_EMIT;
                    n_first = 1'b1;
                    n_emit  = '0;
                end
            end
            S_EMIT: begin
                if (w_load) begin
                    n_emit = r_emit + LEN_W'(1);
                    if (w_last) begin
                        n_state = S_IDLE;
                        n_cnt   = '0;
                        n_drop  = 1'b0;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_drop   <= 1'b0;
            r_first  <= 1'b0;
            r_step   <= '0;
            r_emit   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_drop  <= n_drop;
            r_first <= n_first;
            r_step  <= n_step;
            r_emit  <= n_emit;
            if (w_load) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_char <= n_char;
        r_fin  <= n_fin;
        r_len  <= n_len;
        r_end  <= n_end;
        if (w_load) begin
            r_out.out_char   <= w_em.ch;
            r_out.seq_length <= r_len;
            r_out.overflow   <= r_drop;
            r_out.last_out   <= w_last;
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= MAX_CNT) else $error("stored byte count beyond capacity");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && w_last) |=> (r_state == S_IDLE) && (r_cnt == '0) && !r_drop)
        else $error("string state not cleared after final transfer");

    a_end_stored: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_MAXP) && w_tok_end.v) |-> (w_tok_end.idx < r_cnt) &&
        (w_tok_end.len != '0))
        else $error("chosen end is not a stored position");

endmodule

// ----- design/lis_cell.sv -----
// One cell of the chain: holds one stored byte, its run length and predecessor.
// Depends on lis_pkg for the token, control and emit structs.
module lis_cell #(
    parameter int IDX = 0
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  lis_pkg::t_cell_ctl i_ctl,
    input  lis_pkg::t_tok      i_tok,
    input  lis_pkg::t_btok     i_btok,
    output lis_pkg::t_tok      o_tok,
    output lis_pkg::t_btok     o_btok,
    output lis_pkg::t_emit     o_emit
);
    import lis_pkg::*;

    localparam logic [LEN_W-1:0] MY_IDX = LEN_W'(IDX);

    logic [CHAR_W-1:0] r_ch;
    logic [LEN_W-1:0]  r_rl;
    logic [LEN_W-1:0]  r_pr;
    logic              r_mk;
    logic              n_mk;
    t_tok              r_tok;
    t_tok              n_tok;
    t_btok             r_btok;
    t_btok             n_btok;
    logic              w_below;
    logic              w_here;
    logic              w_stall;
    logic              w_wr;

    assign w_below = MY_IDX < i_ctl.cnt;
    assign w_here  = MY_IDX == i_ctl.cnt;
    // The emit token waits on a marked cell while the output register is full and not taken.
    assign w_stall = (i_ctl.mode == MODE_EMIT) && r_tok.v && r_mk && i_ctl.hold;

    always_comb begin
        n_tok  = i_tok;
        n_btok = '0;
        n_mk   = r_mk;
        w_wr   = 1'b0;
        case (i_ctl.mode)
            MODE_INS: begin
                if (i_tok.v) begin
                    if (w_below) begin
                        if ((i_tok.c > r_ch) && ((r_rl + LEN_W'(1)) > i_tok.len)) begin
                            n_tok.len = r_rl + LEN_W'(1);
                            n_tok.idx = MY_IDX;
                        end
                    end else if (w_here) begin
                        w_wr    = 1'b1;
                        n_tok.v = 1'b0;
                    end
                end
            end
            MODE_MAX: begin
                if (i_tok.v && w_below && (r_rl > i_tok.len)) begin
                    n_tok.len = r_rl;
                    n_tok.idx = MY_IDX;
                end
            end
            MODE_MARK: begin
                if (i_btok.v) begin
                    if (i_btok.want == MY_IDX) begin
                        n_mk = 1'b1;
                        if (r_rl > LEN_W'(1)) begin
                            n_btok.v    = 1'b1;
                            n_btok.want = r_pr;
                        end
                    end else begin
                        n_btok = i_btok;
                    end
                end
            end
            default: begin
                n_tok = i_tok;
            end
        endcase
        if (w_stall) begin
            n_tok = r_tok;
        end
        if (i_ctl.flush) begin
            n_tok.v  = 1'b0;
            n_btok.v = 1'b0;
            n_mk     = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok  <= '0;
            r_btok <= '0;
            r_mk   <= 1'b0;
        end else begin
            r_tok  <= n_tok;
            r_btok <= n_btok;
            r_mk   <= n_mk;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_ch <= i_tok.c;
            r_rl <= i_tok.len;
            r_pr <= i_tok.idx;
        end
    end

    always_comb begin
        o_tok   = r_tok;
        o_tok.v = r_tok.v && !w_stall;
    end

    assign o_btok     = r_btok;
    assign o_emit.req = (i_ctl.mode == MODE_EMIT) && r_tok.v && r_mk;
    assign o_emit.ch  = r_ch;

endmodule

// ----- design/lis_chain.sv -----
// Row of MAX_LEN cells linked in both directions, with the emit byte merge.
// Depends on lis_pkg and lis_cell.
module lis_chain #(
    parameter int MAX_LEN = lis_pkg::C_MAX_LEN
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  lis_pkg::t_cell_ctl i_ctl,
    input  lis_pkg::t_tok      i_tok,
    input  lis_pkg::t_btok     i_btok,
    output lis_pkg::t_tok      o_tok,
    output lis_pkg::t_emit     o_emit
);
    import lis_pkg::*;

    t_tok         w_tl [MAX_LEN+1];
    t_btok        w_bl [MAX_LEN+1];
    t_emit        w_em [MAX_LEN];
    logic [MAX_LEN-1:0] w_req;

    assign w_tl[0]       = i_tok;
    assign w_bl[MAX_LEN] = i_btok;

    for (genvar g = 0; g < MAX_LEN; g++) begin : g_cell
        lis_cell #(
            .IDX(g)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_ctl  (i_ctl),
            .i_tok  (w_tl[g]),
            .i_btok (w_bl[g+1]),
            .o_tok  (w_tl[g+1]),
            .o_btok (w_bl[g]),
            .o_emit (w_em[g])
        );
        assign w_req[g] = w_em[g].req;
    end

    // At most one cell holds the emit token, so an OR merge is enough.
    always_comb begin
        o_emit = '0;
        for (int k = 0; k < MAX_LEN; k++) begin
            o_emit.req = o_emit.req | w_em[k].req;
            if (w_em[k].req) begin
                o_emit.ch = o_emit.ch | w_em[k].ch;
            end
        end
    end

    assign o_tok = w_tl[MAX_LEN];

    // The path walk always ends on a cell of run length one, never past cell zero.
    a_btok_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_bl[0].v) else $error("backward token left the chain");

    a_one_emitter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_req)) else $error("more than one cell requests output");

    // An emit token reaches the end only when the last cell sends the final
    // transfer, and that same transfer flushes it.
    a_end_only_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_tok.v |-> (i_ctl.mode == MODE_MAX) || i_ctl.flush)
        else $error("token reached chain end outside the maximum pass");

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for longest_increasing_subsequence_unit.
// Drives byte strings through the valid/ready input, predicts each emitted subsequence
// and checks every output transfer. Depends on lis_pkg and the design files only.
`timescale 1ns / 100ps

module tb;
    import lis_pkg::*;

    localparam int DIR_ROWS     = 24;
    localparam int RAND_BYTES   = 346;
    localparam int HOLD_CYCLES  = 600;
    localparam int STALL_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 4 * C_MAX_LEN;

    typedef enum int {
        SHAPE_NOISE,
        SHAPE_WALK,
        SHAPE_TIES,
        SHAPE_FALLING,
        SHAPE_RISING
    } t_shape;

    // One directed row: the byte to send and, where it is obvious, the single
    // result that the row's final byte must produce.
    typedef struct packed {
        t_in_item  item;
        logic      typed;
        t_out_item want;
    } t_stim_row;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    t_in_item  i_in_data;
    logic      o_out_valid;
    logic      i_out_ready;
    t_out_item o_out_data;

    // Predictor state, kept at the widths of the block.
    logic [CHAR_W-1:0] lis_chars [C_MAX_LEN];
    logic [LEN_W-1:0]  lis_runs  [C_MAX_LEN];
    logic [LEN_W-1:0]  lis_prev  [C_MAX_LEN];
    int                lis_count;
    logic              lis_dropped;
    t_out_item         lis_expected [$];

    t_stim_row dir_table [DIR_ROWS];

    int  snd_idle_pct;
    int  rcv_idle_pct;
    bit  hold_req;
    bit  hold_served;
    int  mismatch_cnt;
    int  stored_bytes;
    int  strings_done;
    int  overflow_strings;
    int  longest_seen;
    int  results_checked;
    int  stall_cycles;

    longest_increasing_subsequence_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        mismatch_cnt++;
    endtask

    // Advances the predictor by one accepted byte. On a final byte it builds the
    // subsequence ending at the earliest longest run and queues one result per
    // byte when queue_it is set.
    function automatic void advance_lis(input t_in_item item, input bit queue_it);
        int                best;
        int                from;
        int                stop_at;
        int                n;
        int                pos;
        logic [CHAR_W-1:0] path [C_MAX_LEN];
        t_out_item         res;
        if (lis_count < C_MAX_LEN) begin
            best = 1;
            from = 0;
            for (int j = 0; j < lis_count; j++) begin
                // Strict compare, earliest predecessor wins a tie.
                if (item.in_char > lis_chars[j] && int'(lis_runs[j]) + 1 > best) begin
                    best = int'(lis_runs[j]) + 1;
                    from = j;
                end
            end
            lis_chars[lis_count] = item.in_char;
            lis_runs[lis_count]  = LEN_W'(best);
            lis_prev[lis_count]  = LEN_W'(from);
            lis_count++;
            stored_bytes++;
        end else begin
            lis_dropped = 1'b1;
        end
        if (item.final_char) begin
            if (lis_count > 0) begin
                stop_at = 0;
                for (int k = 1; k < lis_count; k++) begin
                    if (lis_runs[k] > lis_runs[stop_at]) stop_at = k;
                end
                n   = int'(lis_runs[stop_at]);
                pos = stop_at;
                for (int k = n - 1; k >= 0; k--) begin
                    path[k] = lis_chars[pos];
                    if (k > 0) pos = int'(lis_prev[pos]);
                end
                for (int k = 0; k < n; k++) begin
                    res.out_char   = path[k];
                    res.seq_length = LEN_W'(n);
                    res.overflow   = lis_dropped;
                    res.last_out   = (k == n - 1);
                    if (queue_it) lis_expected.push_back(res);
                end
                strings_done++;
                if (lis_dropped) overflow_strings++;
                if (n > longest_seen) longest_seen = n;
            end
            lis_count   = 0;
            lis_dropped = 1'b0;
        end
    endfunction

    // Offers one byte and returns at the edge where the transfer happens.
    // Valid is only lowered when an idle gap follows, so back-to-back bytes
    // keep it high without a second assignment in the same step.
    task automatic send_byte(input t_in_item item);
        int idle;
        idle = 0;
        while ($urandom_range(99) < snd_idle_pct) idle++;
        if (idle > 0) begin
            i_in_valid <= 1'b0;
            repeat (idle) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    task automatic send_string(input int len, input t_shape shape);
        t_in_item item;
        int       walk;
        int       base;
        walk = (shape == SHAPE_RISING) ? int'($urandom_range(60)) : int'($urandom_range(255));
        base = $urandom_range(252);
        for (int k = 0; k < len; k++) begin
            case (shape)
                SHAPE_NOISE:   walk = $urandom_range(255);
                SHAPE_WALK:    walk = walk + int'($urandom_range(40)) - 12;
                SHAPE_TIES:    walk = base + int'($urandom_range(3));
                SHAPE_FALLING: walk = walk - int'($urandom_range(20));
                default:       walk = walk + int'($urandom_range(3, 1));
            endcase
            if (walk < 0) walk = 0;
            if (walk > 255) walk = 255;
            item.in_char    = CHAR_W'(walk);
            item.final_char = (k == len - 1);
            send_byte(item);
            advance_lis(item, 1'b1);
        end
    endtask

    // Mostly short strings so that many subsequences come out, now and then a
    // long one of 20 to 64 bytes, up to the whole store.
    task automatic send_random_string();
        int len;
        len = ($urandom_range(11) == 0) ? int'($urandom_range(64, 20))
                                        : int'($urandom_range(10, 1));
        send_string(len, t_shape'($urandom_range(4)));
    endtask

    // Receiver: random ready, except for one long hold that lets the output
    // register fill and the unit stop taking input.
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req && !hold_served) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_served = 1'b1;
            end
            i_out_ready <= ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    // Each output transfer is compared with the oldest pending prediction.
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (lis_expected.size() == 0) begin
                report_mismatch($sformatf("unexpected result, char %0h", o_out_data.out_char));
            end else begin
                want = lis_expected.pop_front();
                results_checked++;
                if (o_out_data.out_char !== want.out_char)
                    report_mismatch($sformatf("out_char %0h, expected %0h",
                                              o_out_data.out_char, want.out_char));
                if (o_out_data.seq_length !== want.seq_length)
                    report_mismatch($sformatf("seq_length %0d, expected %0d",
                                              o_out_data.seq_length, want.seq_length));
                if (o_out_data.overflow !== want.overflow)
                    report_mismatch($sformatf("overflow %0b, expected %0b",
                                              o_out_data.overflow, want.overflow));
                if (o_out_data.last_out !== want.last_out)
                    report_mismatch($sformatf("last_out %0b, expected %0b",
                                              o_out_data.last_out, want.last_out));
            end
        end
    end

    // Watchdog: ends the run when no transfer happens on either side for too long.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("[%0t] watchdog: no transfer for %0d cycles", $realtime, STALL_LIMIT);
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_in_data    = '0;
        snd_idle_pct = 21;
        rcv_idle_pct = 73;
        hold_req     = 1'b0;
        hold_served  = 1'b0;
        mismatch_cnt = 0;
        stored_bytes = 0;
        strings_done = 0;
        overflow_strings = 0;
        longest_seen = 0;
        results_checked = 0;
        stall_cycles = 0;
        lis_count    = 0;
        lis_dropped  = 1'b0;

        dir_table = '{
            // Single-byte strings right after reset, at the extremes and the midpoint.
            '{'{8'h00, 1'b1}, 1'b1, '{8'h00, 7'd1, 1'b0, 1'b1}},
            '{'{8'hFF, 1'b1}, 1'b1, '{8'hFF, 7'd1, 1'b0, 1'b1}},
            '{'{8'h80, 1'b1}, 1'b1, '{8'h80, 7'd1, 1'b0, 1'b1}},
            // Equal bytes do not extend a run; the earliest end is kept.
            '{'{8'h10, 1'b0}, 1'b0, '0},
            '{'{8'h10, 1'b0}, 1'b0, '0},
            '{'{8'h10, 1'b1}, 1'b1, '{8'h10, 7'd1, 1'b0, 1'b1}},
            // A falling string leaves every run at one; the first byte wins.
            '{'{8'hFF, 1'b0}, 1'b0, '0},
            '{'{8'h80, 1'b0}, 1'b0, '0},
            '{'{8'h7F, 1'b0}, 1'b0, '0},
            '{'{8'h00, 1'b1}, 1'b1, '{8'hFF, 7'd1, 1'b0, 1'b1}},
            // Ties between candidate predecessors go to the earliest one.
            '{'{8'h05, 1'b0}, 1'b0, '0},
            '{'{8'h03, 1'b0}, 1'b0, '0},
            '{'{8'h07, 1'b0}, 1'b0, '0},
            '{'{8'h04, 1'b0}, 1'b0, '0},
            '{'{8'h09, 1'b1}, 1'b0, '0},
            // Crossing 7F/80 must compare as unsigned.
            '{'{8'h7F, 1'b0}, 1'b0, '0},
            '{'{8'h80, 1'b0}, 1'b0, '0},
            '{'{8'hFF, 1'b0}, 1'b0, '0},
            '{'{8'h00, 1'b0}, 1'b0, '0},
            '{'{8'h01, 1'b1}, 1'b0, '0},
            // Rising string touching both ends of the byte range.
            '{'{8'h00, 1'b0}, 1'b0, '0},
            '{'{8'h01, 1'b0}, 1'b0, '0},
            '{'{8'hFE, 1'b0}, 1'b0, '0},
            '{'{8'hFF, 1'b1}, 1'b0, '0}
        };

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed rows: typed rows supply their own result, the others the
        // predictor's. The predictor still tracks every byte.
        for (int r = 0; r < DIR_ROWS; r++) begin
            send_byte(dir_table[r].item);
            advance_lis(dir_table[r].item, !dir_table[r].typed);
            if (dir_table[r].typed) lis_expected.push_back(dir_table[r].want);
        end

        // Random part in three idle mixes. The first two open with a long string: a
        // full store and a final mark on a dropped byte; the third sends a later overflow.
        stored_bytes = 0;
        send_string(C_MAX_LEN, SHAPE_RISING);
        while (stored_bytes < 115) send_random_string();

        snd_idle_pct = 73;
        rcv_idle_pct = 21;
        send_string(C_MAX_LEN + 2, SHAPE_RISING);
        while (stored_bytes < 230) send_random_string();

        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        hold_req     = 1'b1;
        send_string(12, SHAPE_RISING);
        while (stored_bytes < 290) send_random_string();
        send_string(C_MAX_LEN + 6, SHAPE_NOISE);
        while (stored_bytes < RAND_BYTES) send_random_string();
        i_in_valid <= 1'b0;

        while (lis_expected.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Run covered %0d strings, %0d of them with dropped bytes, %0d results checked.",
                 strings_done, overflow_strings, results_checked);
        $display("Longest subsequence seen: %0d; idle mixes 21/73, 73/21, none, one long hold.",
                 longest_seen);
        if (mismatch_cnt == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
design/lis_pkg.sv
design/lis_cell.sv
design/lis_chain.sv
design/longest_increasing_subsequence_unit.sv
tb/tb.sv
